// File: sv/scl_pkg.sv
// Shared types and constants for the serial command-line matcher.
// No dependencies; imported by scl_front, scl_back and the top level.
`timescale 1ns / 1ps
`default_nettype none

package scl_pkg;

    // Sizes
    localparam int LINE_LEN     = 32;
    localparam int MAX_COMMANDS = 10;
    localparam int NAME_LEN     = 16;

    localparam int LPOS_W  = $clog2(LINE_LEN);
    localparam int NPOS_W  = $clog2(NAME_LEN);
    localparam int CMP_W   = $clog2(NAME_LEN + 1);
    localparam int NT_DEPTH = MAX_COMMANDS * NAME_LEN;
    localparam int NT_AW   = $clog2(NT_DEPTH);

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int ENTRY_W = 4;
    localparam int POS_W   = 4;
    localparam int KIND_W  = 2;
    localparam int CNT_W   = 4;
    localparam int CFG_IDX_W = 2;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [BYTE_W-1:0] CH_PRINT_LO  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_PRINT_HI  = 8'h7E;
    localparam logic [BYTE_W-1:0] CH_NUL       = 8'h00;

    // Input op codes
    localparam logic OP_RX_BYTE  = 1'b0;
    localparam logic OP_TBL_WR   = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_COUNT = 2'd1;

    // Front queue depth
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_ECHO    = 2'd0,
        KIND_MATCH   = 2'd1,
        KIND_NOMATCH = 2'd2,
        KIND_EMPTY   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CMD_TBL_WR,
        CMD_STORE,
        CMD_NEWLINE
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op               op;
        logic [BYTE_W-1:0]     data;
        logic [ENTRY_W-1:0]    entry;
        logic [POS_W-1:0]      pos;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TOK_RD,
        S_TOK_CHK,
        S_TOK_END,
        S_CMP_RD,
        S_CMP_CHK,
        S_RESULT
    } t_state;

endpackage

`default_nettype wire

// File: sv/scl_front.sv
// Front end: classifies incoming requests and queues the ones that need work.
// Depends on scl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scl_front
    import scl_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    input  wire                i_op,
    input  wire  [BYTE_W-1:0]  i_data_byte,
    input  wire  [ENTRY_W-1:0] i_entry,
    input  wire  [POS_W-1:0]   i_position,
    output logic               o_cmd_valid,
    output t_cmd               o_cmd,
    input  wire                i_cmd_pop
);

    t_cmd              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_cnt, n_cnt;

    logic   accept;
    logic   keep;
    logic   push;
    logic   pop;
    t_cmd   cls;

    // Classification: table writes in range, newline, printable; the rest drops
    always_comb begin
        cls.data  = i_data_byte;
        cls.entry = i_entry;
        cls.pos   = i_position;
        cls.op    = CMD_STORE;
        keep      = 1'b0;
        if (i_op == OP_TBL_WR) begin
            cls.op = CMD_TBL_WR;
            keep   = (32'(i_entry) < MAX_COMMANDS) && (32'(i_position) < NAME_LEN);
        end else if (i_data_byte == CH_NEWLINE) begin
            cls.op = CMD_NEWLINE;
            keep   = 1'b1;
        end else if (i_data_byte >= CH_PRINT_LO && i_data_byte <= CH_PRINT_HI) begin
            cls.op = CMD_STORE;
            keep   = 1'b1;
        end
    end

    assign o_stall     = (r_cnt == QCNT_W'(QDEPTH));
    assign accept      = i_valid && !o_stall;
    assign push        = accept && keep;
    assign o_cmd_valid = (r_cnt != '0);
    assign pop         = o_cmd_valid && i_cmd_pop;
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (push) begin
            n_wr_ptr = (32'(r_wr_ptr) == QDEPTH - 1) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (32'(r_rd_ptr) == QDEPTH - 1) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cls;
        end
    end

endmodule

`default_nettype wire

// File: sv/scl_back.sv
// Back end: line store, command name table, newline scan sequencer and the
// result register. Depends on scl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scl_back
    import scl_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_echo_en,
    input  wire  [CNT_W-1:0]   i_cmd_count,
    input  wire                i_cmd_valid,
    input  wire  t_cmd         i_cmd,
    output logic               o_cmd_pop,
    output logic               o_valid,
    input  wire                i_stall,
    output logic [KIND_W-1:0]  o_kind,
    output logic [BYTE_W-1:0]  o_echo_char,
    output logic [ENTRY_W-1:0] o_command_index
);

    // Memories
    logic [BYTE_W-1:0] mem_line [LINE_LEN];
    logic [BYTE_W-1:0] mem_name [NT_DEPTH];
    logic [BYTE_W-1:0] r_line_rd;
    logic [BYTE_W-1:0] r_name_rd;

    logic              line_we;
    logic [LPOS_W-1:0] line_waddr;
    logic [LPOS_W-1:0] line_raddr;
    logic              name_we;
    logic [NT_AW-1:0]  name_waddr;
    logic [NT_AW-1:0]  name_raddr;

    // Sequencer state
    t_state             r_state, n_state;
    logic [LPOS_W-1:0]  r_wpos, n_wpos;
    logic [LPOS_W-1:0]  r_len, n_len;
    logic [LPOS_W-1:0]  r_j, n_j;
    logic [LPOS_W-1:0]  r_start, n_start;
    logic [LPOS_W-1:0]  r_tlen, n_tlen;
    logic               r_in_tok, n_in_tok;
    logic [ENTRY_W-1:0] r_e, n_e;
    logic [CMP_W-1:0]   r_i, n_i;
    logic [CNT_W-1:0]   r_limit, n_limit;
    t_kind              r_res_kind, n_res_kind;
    logic [ENTRY_W-1:0] r_res_idx, n_res_idx;

    // Result register
    logic               r_out_valid, n_out_valid;
    t_kind              r_out_kind, n_out_kind;
    logic [BYTE_W-1:0]  r_out_char, n_out_char;
    logic [ENTRY_W-1:0] r_out_idx, n_out_idx;

    logic               out_free;
    logic [BYTE_W-1:0]  cmp_a;
    logic [BYTE_W-1:0]  cmp_b;

    assign out_free = !r_out_valid || !i_stall;

    assign cmp_a = (32'(r_i) < 32'(r_tlen)) ? r_line_rd : CH_NUL;
    assign cmp_b = (32'(r_i) >= NAME_LEN)   ? CH_NUL    : r_name_rd;

    assign line_raddr = (r_state == S_TOK_RD) ? r_j
                                              : LPOS_W'(32'(r_start) + 32'(r_i));
    assign name_raddr = NT_AW'(32'(r_e) * NAME_LEN + 32'(r_i[NPOS_W-1:0]));

    always_comb begin
        n_state     = r_state;
        n_wpos      = r_wpos;
        n_len       = r_len;
        n_j         = r_j;
        n_start     = r_start;
        n_tlen      = r_tlen;
        n_in_tok    = r_in_tok;
        n_e         = r_e;
        n_i         = r_i;
        n_limit     = r_limit;
        n_res_kind  = r_res_kind;
        n_res_idx   = r_res_idx;
        n_out_valid = r_out_valid && i_stall;
        n_out_kind  = r_out_kind;
        n_out_char  = r_out_char;
        n_out_idx   = r_out_idx;
        o_cmd_pop   = 1'b0;
        line_we     = 1'b0;
        line_waddr  = r_wpos;
        name_we     = 1'b0;
        name_waddr  = NT_AW'(32'(i_cmd.entry) * NAME_LEN + 32'(i_cmd.pos));

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        CMD_TBL_WR: begin
                            o_cmd_pop = 1'b1;
                            name_we   = 1'b1;
                        end
                        CMD_STORE: begin
                            if (!i_echo_en || out_free) begin
                                o_cmd_pop = 1'b1;
                                line_we   = 1'b1;
                                n_wpos    = (32'(r_wpos) == LINE_LEN - 1) ? '0
                                                                          : r_wpos + 1'b1;
                                if (i_echo_en) begin
                                    n_out_valid = 1'b1;
                                    n_out_kind  = KIND_ECHO;
                                    n_out_char  = i_cmd.data;
                                    n_out_idx   = '0;
                                end
                            end
                        end
                        CMD_NEWLINE: begin
                            o_cmd_pop = 1'b1;
                            n_len     = r_wpos;
                            n_wpos    = '0;
                            n_j       = '0;
                            n_tlen    = '0;
                            n_start   = '0;
                            n_in_tok  = 1'b0;
                            n_limit   = (32'(i_cmd_count) > MAX_COMMANDS)
                                        ? CNT_W'(MAX_COMMANDS) : i_cmd_count;
                            n_state   = S_TOK_RD;
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_TOK_RD: begin
                n_state = (r_j == r_len) ? S_TOK_END : S_TOK_CHK;
            end
            S_TOK_CHK: begin
                if (!r_in_tok) begin
                    if (r_line_rd != CH_SPACE) begin
                        n_start  = r_j;
                        n_in_tok = 1'b1;
                        n_tlen   = LPOS_W'(1);
                    end
                    n_j     = r_j + 1'b1;
                    n_state = S_TOK_RD;
                end else if (r_line_rd == CH_SPACE) begin
                    n_state = S_TOK_END;
                end else begin
                    n_tlen  = r_tlen + 1'b1;
                    n_j     = r_j + 1'b1;
                    n_state = S_TOK_RD;
                end
            end
            S_TOK_END: begin
                n_e       = '0;
                n_i       = '0;
                n_res_idx = '0;
                if (r_tlen == '0) begin
                    n_res_kind = KIND_EMPTY;
                    n_state    = S_RESULT;
                end else if (r_limit == '0) begin
                    n_res_kind = KIND_NOMATCH;
                    n_state    = S_RESULT;
                end else begin
                    n_state = S_CMP_RD;
                end
            end
            S_CMP_RD: begin
                n_state = S_CMP_CHK;
            end
            S_CMP_CHK: begin
                if (cmp_a != cmp_b) begin
                    if (CNT_W'(r_e) + 1'b1 == r_limit) begin
                        n_res_kind = KIND_NOMATCH;
                        n_res_idx  = '0;
                        n_state    = S_RESULT;
                    end else begin
                        n_e     = r_e + 1'b1;
                        n_i     = '0;
                        n_state = S_CMP_RD;
                    end
                end else if (cmp_a == CH_NUL) begin
                    n_res_kind = KIND_MATCH;
                    n_res_idx  = r_e;
                    n_state    = S_RESULT;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_CMP_RD;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_res_kind;
                    n_out_char  = '0;
                    n_out_idx   = r_res_idx;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wpos      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wpos      <= n_wpos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len      <= n_len;
        r_j        <= n_j;
        r_start    <= n_start;
        r_tlen     <= n_tlen;
        r_in_tok   <= n_in_tok;
        r_e        <= n_e;
        r_i        <= n_i;
        r_limit    <= n_limit;
        r_res_kind <= n_res_kind;
        r_res_idx  <= n_res_idx;
        r_out_kind <= n_out_kind;
        r_out_char <= n_out_char;
        r_out_idx  <= n_out_idx;
    end

    always_ff @(posedge i_clk) begin
        if (line_we) begin
            mem_line[line_waddr] <= i_cmd.data;
        end
        r_line_rd <= mem_line[line_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (name_we) begin
            mem_name[name_waddr] <= i_cmd.data;
        end
        r_name_rd <= mem_name[name_raddr];
    end

    assign o_valid         = r_out_valid;
    assign o_kind          = r_out_kind;
    assign o_echo_char     = r_out_char;
    assign o_command_index = r_out_idx;

    // Name compares only run on a non-empty token with at least one entry
    a_cmp_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP_RD || r_state == S_CMP_CHK) |-> (r_tlen != '0 && r_limit != '0))
        else $error("compare with empty token or empty table");

    // Entry under compare stays within the searched range
    a_entry_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP_RD || r_state == S_CMP_CHK) |-> (CNT_W'(r_e) < r_limit))
        else $error("compare entry beyond limit");

    // A name compare ends by the terminator slot
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP_CHK) |-> (32'(r_i) <= NAME_LEN))
        else $error("compare index ran past name length");

    // Echo results only come out of the idle state
    a_echo_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_out_valid && !(r_out_valid && i_stall) && n_out_kind == KIND_ECHO)
            |-> (r_state == S_IDLE))
        else $error("echo issued during line scan");

endmodule

`default_nettype wire

// File: sv/serial_command_line_matcher.sv
// A printable byte's echo goes through the front queue and then the result register; a table
// write completes when the back end pops it. A newline's result follows a token scan of the line
// and a compare against the names, each a read state then a check state per character.
// Throughput: one byte or table write per cycle into a 2-deep queue unless full, drained at one
// per cycle by the idle back end (an echo waits for a free result register); the scan sets the rate.
// Reset (synchronous, active low) empties the line and queue; the name table is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module serial_command_line_matcher
    import scl_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // Request channel
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire                  i_op,
    input  wire  [BYTE_W-1:0]    i_data_byte,
    input  wire  [ENTRY_W-1:0]   i_entry,
    input  wire  [POS_W-1:0]     i_position,
    // Result channel
    output logic                 o_valid,
    input  wire                  i_stall,
    output logic [KIND_W-1:0]    o_kind,
    output logic [BYTE_W-1:0]    o_echo_char,
    output logic [ENTRY_W-1:0]   o_command_index,
    // Configuration write channel
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [CNT_W-1:0]     i_cfg_data
);

    // Configuration registers; writes are always taken
    logic             r_echo_en;
    logic [CNT_W-1:0] r_cmd_count;
    logic             cfg_wr;

    // Queue handoff between front and back
    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo_en   <= 1'b0;
            r_cmd_count <= '0;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                CFG_ECHO_ENABLE:   r_echo_en   <= i_cfg_data[0];
                CFG_COMMAND_COUNT: r_cmd_count <= i_cfg_data;
                default: ;  // unknown index: dropped
            endcase
        end
    end

    // Front: classify each request, drop non-printables and out-of-range table writes, queue the rest
    scl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_data_byte (i_data_byte),
        .i_entry     (i_entry),
        .i_position  (i_position),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // Back: line buffer, name table, token scan and match, result register
    scl_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_echo_en       (r_echo_en),
        .i_cmd_count     (r_cmd_count),
        .i_cmd_valid     (cmd_valid),
        .i_cmd           (cmd),
        .o_cmd_pop       (cmd_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_echo_char     (o_echo_char),
        .o_command_index (o_command_index)
    );

endmodule

`default_nettype wire

// File: tb/tb_serial_command_line_matcher.sv
// Self-checking testbench for serial_command_line_matcher: a line predictor checks echoes
// and match results. Depends on scl_pkg and the serial_command_line_matcher RTL.
`timescale 1ns / 1ps

module tb_serial_command_line_matcher;
    import scl_pkg::*;

    // Token and name are compared over at most this many characters
    localparam int TOKEN_CMP_MAX = 32;
    // Register indexes that the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
    // Cycles to let requests with no result retire before a register write
    localparam int SETTLE_CYCLES = 32;
    // Quiet cycles allowed: worst newline scan plus the long hold, with margin
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS = 550;

    typedef struct {
        t_kind              kind;
        logic [BYTE_W-1:0]  echo_char;
        logic [ENTRY_W-1:0] cmd_index;
    } t_line_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic                 i_op = OP_RX_BYTE;
    logic [BYTE_W-1:0]    i_data_byte = '0;
    logic [ENTRY_W-1:0]   i_entry = '0;
    logic [POS_W-1:0]     i_position = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [KIND_W-1:0]    o_kind;
    logic [BYTE_W-1:0]    o_echo_char;
    logic [ENTRY_W-1:0]   o_command_index;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CNT_W-1:0]     i_cfg_data = '0;

    serial_command_line_matcher i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_data_byte     (i_data_byte),
        .i_entry         (i_entry),
        .i_position      (i_position),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_echo_char     (o_echo_char),
        .o_command_index (o_command_index),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the line, the name table and config
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0]  line_buf [LINE_LEN];
    int                 line_wr_pos;
    logic [BYTE_W-1:0]  name_tbl [MAX_COMMANDS][NAME_LEN];
    logic               echo_en;
    logic [CNT_W-1:0]   cmd_cnt;

    t_line_result       pending_results [$];
    int                 requests_sent;
    int                 mismatches;
    int                 tx_idle_pct;
    int                 rx_idle_pct;
    int                 quiet_cycles = 0;
    // Long receiver hold: test side bumps hold_asks, receiver process acknowledges
    int                 hold_asks;
    int                 hold_seen = 0;
    int                 hold_left = 0;

    task automatic clear_line_buf();
        foreach (line_buf[k]) line_buf[k] = CH_NUL;
        line_wr_pos = 0;
    endtask

    // Does the token at line_buf[start +: tlen] equal name entry e?
    function automatic bit token_matches(input int e, input int start, input int tlen);
        int                nlen;
        int                k;
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] c;
        nlen = 0;
        while (nlen < NAME_LEN && name_tbl[e][nlen] != CH_NUL) nlen++;
        for (k = 0; k < TOKEN_CMP_MAX; k++) begin
            a = CH_NUL;
            c = CH_NUL;
            if (k < tlen) a = line_buf[start + k];
            if (k < nlen) c = name_tbl[e][k];
            if (a != c) return 1'b0;
            if (a == CH_NUL) return 1'b1;
        end
        // equal over the whole compare window counts as a match
        return 1'b1;
    endfunction

    // Update the predicted line state for one accepted request and queue its result
    task automatic predict_request(input logic op, input logic [BYTE_W-1:0] b,
                                   input logic [ENTRY_W-1:0] ent,
                                   input logic [POS_W-1:0] pos);
        t_line_result r;
        int           len;
        int           start;
        int           tlen;
        int           limit;
        int           e;
        bit           found;
        r.kind      = KIND_ECHO;
        r.echo_char = '0;
        r.cmd_index = '0;
        if (op == OP_TBL_WR) begin
            // out-of-range entries are dropped
            if (ent < MAX_COMMANDS && pos < NAME_LEN) begin
                name_tbl[ent][pos] = b;
                requests_sent++;
            end
        end else if (b == CH_NEWLINE) begin
            len = 0;
            while (len < LINE_LEN && line_buf[len] != CH_NUL) len++;
            start = 0;
            while (start < len && line_buf[start] == CH_SPACE) start++;
            tlen = 0;
            while (start + tlen < len && line_buf[start + tlen] != CH_SPACE) tlen++;
            if (tlen == 0) begin
                r.kind = KIND_EMPTY;
            end else begin
                r.kind = KIND_NOMATCH;
                // count above the table size searches the whole table
                limit = (cmd_cnt < MAX_COMMANDS) ? int'(cmd_cnt) : MAX_COMMANDS;
                found = 1'b0;
                for (e = 0; e < limit; e++) begin
                    if (!found && token_matches(e, start, tlen)) begin
                        found       = 1'b1;
                        r.kind      = KIND_MATCH;
                        r.cmd_index = e[ENTRY_W-1:0];
                    end
                end
            end
            clear_line_buf();
            pending_results.push_back(r);
            requests_sent++;
        end else if (b >= CH_PRINT_LO && b <= CH_PRINT_HI) begin
            line_buf[line_wr_pos] = b;
            // wrap restarts the line: terminator lands on index 0
            line_wr_pos = (line_wr_pos == LINE_LEN - 1) ? 0 : line_wr_pos + 1;
            line_buf[line_wr_pos] = CH_NUL;
            if (echo_en) begin
                r.echo_char = b;
                pending_results.push_back(r);
            end
            requests_sent++;
        end
        // any other byte is dropped by the block
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    task automatic send_request(input logic op, input logic [BYTE_W-1:0] b,
                                input logic [ENTRY_W-1:0] ent,
                                input logic [POS_W-1:0] pos);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        // valid stays high across back-to-back requests; payload moves only on acceptance
        i_valid     <= 1'b1;
        i_op        <= op;
        i_data_byte <= b;
        i_entry     <= ent;
        i_position  <= pos;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_request(op, b, ent, pos);
    endtask

    task automatic send_rx_byte(input logic [BYTE_W-1:0] b);
        // entry and position are don't-care here; randomize them anyway
        send_request(OP_RX_BYTE, b, ENTRY_W'($urandom_range(15)), POS_W'($urandom_range(15)));
    endtask

    task automatic send_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) send_rx_byte(s[k]);
    endtask

    task automatic load_name(input int e, input string s);
        int k;
        for (k = 0; k < s.len(); k++)
            send_request(OP_TBL_WR, s[k], ENTRY_W'(e), POS_W'(k));
        if (s.len() < NAME_LEN) send_request(OP_TBL_WR, CH_NUL, ENTRY_W'(e), POS_W'(s.len()));
    endtask

    // Random name, mostly lowercase letters; entries 10..15 are dropped by the block
    task automatic load_random_name(input int e);
        int                len;
        int                k;
        logic [BYTE_W-1:0] c;
        len = $urandom_range(1, NAME_LEN);
        for (k = 0; k < len; k++) begin
            c = ($urandom_range(9) == 0) ? BYTE_W'($urandom_range(1, 255))
                                         : BYTE_W'(8'h61 + $urandom_range(25));
            send_request(OP_TBL_WR, c, ENTRY_W'(e), POS_W'(k));
        end
        if (len < NAME_LEN) send_request(OP_TBL_WR, CH_NUL, ENTRY_W'(e), POS_W'(len));
    endtask

    function automatic logic [BYTE_W-1:0] noise_byte();
        logic [BYTE_W-1:0] b;
        b = CH_NEWLINE;
        while (b == CH_NEWLINE)
            b = ($urandom_range(1) == 0) ? BYTE_W'($urandom_range(8'h1F))
                                         : BYTE_W'($urandom_range(8'h7F, 8'hFF));
        return b;
    endfunction

    // One command line: optional leading spaces, a token, optional arguments, newline
    task automatic send_random_line();
        logic [BYTE_W-1:0] line_q [$];
        int                pick;
        int                e;
        int                k;
        int                lead;
        int                noise_at;
        pick = $urandom_range(99);
        lead = ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 3);
        repeat (lead) line_q.push_back(CH_SPACE);
        if (pick < 60) begin
            // a table name, sometimes off by one character
            e = $urandom_range(MAX_COMMANDS - 1);
            k = 0;
            while (k < NAME_LEN && name_tbl[e][k] != CH_NUL) begin
                line_q.push_back(name_tbl[e][k]);
                k++;
            end
            if (pick >= 45) begin
                if ($urandom_range(1) == 0 && line_q.size() > lead) void'(line_q.pop_back());
                else line_q.push_back(BYTE_W'(8'h61 + $urandom_range(25)));
            end
        end else if (pick < 70) begin
            // blank line
        end else if (pick < 80) begin
            // long token, runs into the line wrap
            repeat ($urandom_range(17, 40)) line_q.push_back(BYTE_W'(8'h61 + $urandom_range(25)));
        end else begin
            repeat ($urandom_range(1, 8)) line_q.push_back(BYTE_W'($urandom_range(8'h21, 8'h7E)));
        end
        if ($urandom_range(99) < 40) begin
            line_q.push_back(CH_SPACE);
            repeat ($urandom_range(1, 10)) line_q.push_back(BYTE_W'($urandom_range(8'h20, 8'h7E)));
        end
        noise_at = ($urandom_range(9) == 0) ? $urandom_range(line_q.size()) : -1;
        for (k = 0; k < line_q.size(); k++) begin
            if (k == noise_at) send_rx_byte(noise_byte());
            send_rx_byte(line_q[k]);
        end
        if (noise_at == line_q.size()) send_rx_byte(noise_byte());
        send_rx_byte(CH_NEWLINE);
    endtask

    // Wait for every expected result, then let result-free requests retire
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_ECHO_ENABLE) echo_en = val[0];
        else if (idx == CFG_COMMAND_COUNT) cmd_cnt = val;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall, plus a long hold on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_seen != hold_asks) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_line_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result: expected none, actual kind %0d char %0h idx %0d",
                         $time, o_kind, o_echo_char, o_command_index);
            end else begin
                want = pending_results.pop_front();
                if (o_kind !== want.kind) begin
                    mismatches++;
                    $display("%0t: kind: expected %0d actual %0d", $time, want.kind, o_kind);
                end
                if (o_echo_char !== want.echo_char) begin
                    mismatches++;
                    $display("%0t: echo_char: expected %0h actual %0h",
                             $time, want.echo_char, o_echo_char);
                end
                if (o_command_index !== want.cmd_index) begin
                    mismatches++;
                    $display("%0t: command_index: expected %0d actual %0d",
                             $time, want.cmd_index, o_command_index);
                end
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb_serial_command_line_matcher: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Write every table character once so no match ever reads an unwritten one,
    // then load the working names (entry 3 duplicates entry 0, entry 4 is full length)
    task automatic test_table_setup();
        int e;
        int p;
        for (e = 0; e < MAX_COMMANDS; e++)
            for (p = 0; p < NAME_LEN; p++)
                send_request(OP_TBL_WR, CH_NUL, ENTRY_W'(e), POS_W'(p));
        // entries past the table are dropped
        send_request(OP_TBL_WR, 8'hFF, 4'd10, 4'd15);
        send_request(OP_TBL_WR, 8'hFF, 4'd15, 4'd0);
        load_name(0, "help");
        load_name(1, "set");
        load_name(2, "get");
        load_name(3, "help");
        load_name(4, "abcdefghijklmnop");
        load_name(5, "x");
        load_name(6, "~~");
        load_name(7, "reset");
        load_name(8, "go");
        load_name(9, "status");
        drain_results();
    endtask

    task automatic test_config_regs();
        // undecoded indexes must not disturb anything
        write_config(CFG_SPARE_LO, 4'hF);
        write_config(CFG_SPARE_HI, 4'h5);
        write_config(CFG_ECHO_ENABLE, 4'hF);
        write_config(CFG_COMMAND_COUNT, 4'd10);
    endtask

    task automatic test_directed_lines();
        send_text("help\n");           // first of two equal names wins
        send_text("  go x\n");         // leading spaces, argument
        send_rx_byte(CH_NEWLINE);      // empty line
        send_rx_byte(CH_SPACE);
        send_rx_byte(8'h7F);           // non-printables are dropped
        send_rx_byte(8'h01);
        send_rx_byte(8'hFF);
        send_rx_byte(8'h00);
        send_text(" \n");              // spaces only: empty
        send_text("hel\n");            // prefix of a name: no match
        drain_results();
    endtask

    // Receiver holds off while the sender keeps pushing echoes, then the
    // sender pauses until everything has come back
    task automatic test_backpressure();
        int sv_tx;
        sv_tx       = tx_idle_pct;
        tx_idle_pct = 0;
        hold_asks++;
        repeat (40) send_rx_byte(BYTE_W'(8'h61 + $urandom_range(25)));
        send_text("\nset a\n");
        tx_idle_pct = sv_tx;
        drain_results();
        send_text("get\n");
        drain_results();
    endtask

    task automatic test_random_phase(input logic echo, input logic [CNT_W-1:0] cnt,
                                     input int tx_pct, input int rx_pct, input int n_items);
        int stop_at;
        int r;
        drain_results();
        write_config(CFG_ECHO_ENABLE, {3'($urandom_range(7)), echo});
        write_config(CFG_COMMAND_COUNT, cnt);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        stop_at     = requests_sent + n_items;
        while (requests_sent < stop_at) begin
            r = $urandom_range(99);
            if (r < 80) begin
                send_random_line();
            end else if (r < 88) begin
                load_random_name($urandom_range(15));
            end else if (r < 94) begin
                send_request(OP_TBL_WR, BYTE_W'($urandom_range(255)),
                             ENTRY_W'($urandom_range(15)), POS_W'($urandom_range(15)));
            end else begin
                repeat ($urandom_range(1, 5)) send_rx_byte(BYTE_W'($urandom_range(255)));
            end
        end
        drain_results();
    endtask

    initial begin
        requests_sent = 0;
        mismatches    = 0;
        hold_asks     = 0;
        tx_idle_pct   = 26;
        rx_idle_pct   = 26;
        echo_en       = 1'b0;
        cmd_cnt       = '0;
        clear_line_buf();
        foreach (name_tbl[e, p]) name_tbl[e][p] = CH_NUL;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_table_setup();
        test_config_regs();
        test_directed_lines();
        test_backpressure();
        test_random_phase(1'b1, 4'd10, 26, 26, RANDOM_ITEMS / 5);
        test_random_phase(1'b0, 4'd0,  26, 26, RANDOM_ITEMS / 5);
        // a stretch with no idling on either side; count above the table size
        test_random_phase(1'b1, 4'd15, 0,  0,  RANDOM_ITEMS / 5);
        test_random_phase(1'b0, 4'd1,  26, 26, RANDOM_ITEMS / 5);
        test_random_phase(1'($urandom_range(1)), CNT_W'($urandom_range(15)), 26, 26,
                          RANDOM_ITEMS / 5);

        drain_results();
        if (mismatches == 0)
            $display("tb_serial_command_line_matcher: clean");
        else
            $display("tb_serial_command_line_matcher: errors");
        $finish;
    end

endmodule

// File: serial_command_line_matcher.f
sv/scl_pkg.sv
sv/scl_front.sv
sv/scl_back.sv
sv/serial_command_line_matcher.sv
tb/tb_serial_command_line_matcher.sv
